>>> sv/ucm_pkg.sv
// ucm_pkg: shared types, constants and range tables of the unicode case mapper
// holds the lower-case and upper-case range roms and the stride test
// no dependencies
`timescale 1ns / 1ps

package ucm_pkg;

	localparam int CODE_BITS       = 21;
	localparam int RANGE_ROM_DEPTH = 256;

	// search position runs 0..n, n at most the rom depth
	localparam int POS_W        = $clog2(RANGE_ROM_DEPTH + 1);
	localparam int IDX_W        = $clog2(RANGE_ROM_DEPTH);
	localparam int SEARCH_STEPS = POS_W;
	// input register, search stages, entry read, map and output register
	localparam int PIPE_LATENCY = SEARCH_STEPS + 3;

	localparam int LOWER_ROWS = 174;
	localparam int UPPER_ROWS = 188;
	localparam int LOWER_N = (LOWER_ROWS < RANGE_ROM_DEPTH) ? LOWER_ROWS : RANGE_ROM_DEPTH;
	localparam int UPPER_N = (UPPER_ROWS < RANGE_ROM_DEPTH) ? UPPER_ROWS : RANGE_ROM_DEPTH;

	localparam int ASCII_LIMIT = 128;
	localparam int SHARP_S     = 'hdf;
	localparam int ASCII_CASE  = 32;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [15:0]          diff_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] lo;
		logic [CODE_BITS-1:0] hi;
		logic signed [15:0]   stride;
		logic signed [17:0]   delta;
	} span_t;

	localparam span_t LOWER_ROM [LOWER_ROWS] = '{
		'{'h41,'h5a,1,32},'{'hc0,'hd6,1,32},'{'hd8,'hde,1,32},'{'h100,'h12e,2,1},
		'{'h130,'h130,-1,-199},'{'h132,'h136,2,1},'{'h139,'h147,2,1},'{'h14a,'h176,2,1},
		'{'h178,'h178,-1,-121},'{'h179,'h17d,2,1},'{'h181,'h181,-1,210},'{'h182,'h184,2,1},
		'{'h186,'h186,-1,206},'{'h187,'h187,-1,1},'{'h189,'h18a,1,205},'{'h18b,'h18b,-1,1},
		'{'h18e,'h18e,-1,79},'{'h18f,'h18f,-1,202},'{'h190,'h190,-1,203},'{'h191,'h191,-1,1},
		'{'h193,'h193,-1,205},'{'h194,'h194,-1,207},'{'h196,'h196,-1,211},'{'h197,'h197,-1,209},
		'{'h198,'h198,-1,1},'{'h19c,'h19c,-1,211},'{'h19d,'h19d,-1,213},'{'h19f,'h19f,-1,214},
		'{'h1a0,'h1a4,2,1},'{'h1a6,'h1a6,-1,218},'{'h1a7,'h1a7,-1,1},'{'h1a9,'h1a9,-1,218},
		'{'h1ac,'h1ac,-1,1},'{'h1ae,'h1ae,-1,218},'{'h1af,'h1af,-1,1},'{'h1b1,'h1b2,1,217},
		'{'h1b3,'h1b5,2,1},'{'h1b7,'h1b7,-1,219},'{'h1b8,'h1bc,4,1},'{'h1c4,'h1c4,-1,2},
		'{'h1c5,'h1c5,-1,1},'{'h1c7,'h1c7,-1,2},'{'h1c8,'h1c8,-1,1},'{'h1ca,'h1ca,-1,2},
		'{'h1cb,'h1db,2,1},'{'h1de,'h1ee,2,1},'{'h1f1,'h1f1,-1,2},'{'h1f2,'h1f4,2,1},
		'{'h1f6,'h1f6,-1,-97},'{'h1f7,'h1f7,-1,-56},'{'h1f8,'h21e,2,1},'{'h220,'h220,-1,-130},
		'{'h222,'h232,2,1},'{'h23a,'h23a,-1,10795},'{'h23b,'h23b,-1,1},'{'h23d,'h23d,-1,-163},
		'{'h23e,'h23e,-1,10792},'{'h241,'h241,-1,1},'{'h243,'h243,-1,-195},'{'h244,'h244,-1,69},
		'{'h245,'h245,-1,71},'{'h246,'h24e,2,1},'{'h370,'h372,2,1},'{'h376,'h376,-1,1},
		'{'h37f,'h37f,-1,116},'{'h386,'h386,-1,38},'{'h388,'h38a,1,37},'{'h38c,'h38c,-1,64},
		'{'h38e,'h38f,1,63},'{'h391,'h3a1,1,32},'{'h3a3,'h3ab,1,32},'{'h3cf,'h3cf,-1,8},
		'{'h3d8,'h3ee,2,1},'{'h3f4,'h3f4,-1,-60},'{'h3f7,'h3f7,-1,1},'{'h3f9,'h3f9,-1,-7},
		'{'h3fa,'h3fa,-1,1},'{'h3fd,'h3ff,1,-130},'{'h400,'h40f,1,80},'{'h410,'h42f,1,32},
		'{'h460,'h480,2,1},'{'h48a,'h4be,2,1},'{'h4c0,'h4c0,-1,15},'{'h4c1,'h4cd,2,1},
		'{'h4d0,'h52e,2,1},'{'h531,'h556,1,48},'{'h10a0,'h10c5,1,7264},'{'h10c7,'h10cd,6,7264},
		'{'h13a0,'h13ef,1,38864},'{'h13f0,'h13f5,1,8},'{'h1c90,'h1cba,1,-3008},
		'{'h1cbd,'h1cbf,1,-3008},
		'{'h1e00,'h1e94,2,1},'{'h1e9e,'h1e9e,-1,-7615},'{'h1ea0,'h1efe,2,1},'{'h1f08,'h1f0f,1,-8},
		'{'h1f18,'h1f1d,1,-8},'{'h1f28,'h1f2f,1,-8},'{'h1f38,'h1f3f,1,-8},'{'h1f48,'h1f4d,1,-8},
		'{'h1f59,'h1f5f,2,-8},'{'h1f68,'h1f6f,1,-8},'{'h1f88,'h1f8f,1,-8},'{'h1f98,'h1f9f,1,-8},
		'{'h1fa8,'h1faf,1,-8},'{'h1fb8,'h1fb9,1,-8},'{'h1fba,'h1fbb,1,-74},'{'h1fbc,'h1fbc,-1,-9},
		'{'h1fc8,'h1fcb,1,-86},'{'h1fcc,'h1fcc,-1,-9},'{'h1fd8,'h1fd9,1,-8},'{'h1fda,'h1fdb,1,-100},
		'{'h1fe8,'h1fe9,1,-8},'{'h1fea,'h1feb,1,-112},'{'h1fec,'h1fec,-1,-7},
		'{'h1ff8,'h1ff9,1,-128},
		'{'h1ffa,'h1ffb,1,-126},'{'h1ffc,'h1ffc,-1,-9},'{'h2126,'h2126,-1,-7517},
		'{'h212a,'h212a,-1,-8383},
		'{'h212b,'h212b,-1,-8262},'{'h2132,'h2132,-1,28},'{'h2160,'h216f,1,16},
		'{'h2183,'h2183,-1,1},
		'{'h24b6,'h24cf,1,26},'{'h2c00,'h2c2e,1,48},'{'h2c60,'h2c60,-1,1},
		'{'h2c62,'h2c62,-1,-10743},
		'{'h2c63,'h2c63,-1,-3814},'{'h2c64,'h2c64,-1,-10727},'{'h2c67,'h2c6b,2,1},
		'{'h2c6d,'h2c6d,-1,-10780},
		'{'h2c6e,'h2c6e,-1,-10749},'{'h2c6f,'h2c6f,-1,-10783},'{'h2c70,'h2c70,-1,-10782},
		'{'h2c72,'h2c75,3,1},
		'{'h2c7e,'h2c7f,1,-10815},'{'h2c80,'h2ce2,2,1},'{'h2ceb,'h2ced,2,1},
		'{'h2cf2,'ha640,31054,1},
		'{'ha642,'ha66c,2,1},'{'ha680,'ha69a,2,1},'{'ha722,'ha72e,2,1},'{'ha732,'ha76e,2,1},
		'{'ha779,'ha77b,2,1},'{'ha77d,'ha77d,-1,-35332},'{'ha77e,'ha786,2,1},'{'ha78b,'ha78b,-1,1},
		'{'ha78d,'ha78d,-1,-42280},'{'ha790,'ha792,2,1},'{'ha796,'ha7a8,2,1},
		'{'ha7aa,'ha7aa,-1,-42308},
		'{'ha7ab,'ha7ab,-1,-42319},'{'ha7ac,'ha7ac,-1,-42315},'{'ha7ad,'ha7ad,-1,-42305},
		'{'ha7ae,'ha7ae,-1,-42308},
		'{'ha7b0,'ha7b0,-1,-42258},'{'ha7b1,'ha7b1,-1,-42282},'{'ha7b2,'ha7b2,-1,-42261},
		'{'ha7b3,'ha7b3,-1,928},
		'{'ha7b4,'ha7be,2,1},'{'ha7c2,'ha7c2,-1,1},'{'ha7c4,'ha7c4,-1,-48},
		'{'ha7c5,'ha7c5,-1,-42307},
		'{'ha7c6,'ha7c6,-1,-35384},'{'ha7c7,'ha7c9,2,1},'{'ha7f5,'ha7f5,-1,1},
		'{'hff21,'hff3a,1,32},
		'{'h10400,'h10427,1,40},'{'h104b0,'h104d3,1,40},'{'h10c80,'h10cb2,1,64},
		'{'h118a0,'h118bf,1,32},
		'{'h16e40,'h16e5f,1,32},'{'h1e900,'h1e921,1,34}
	};

	localparam span_t UPPER_ROM [UPPER_ROWS] = '{
		'{'h61,'h7a,1,-32},'{'hb5,'hb5,-1,743},'{'he0,'hf6,1,-32},'{'hf8,'hfe,1,-32},
		'{'hff,'hff,-1,121},'{'h101,'h12f,2,-1},'{'h131,'h131,-1,-232},'{'h133,'h137,2,-1},
		'{'h13a,'h148,2,-1},'{'h14b,'h177,2,-1},'{'h17a,'h17e,2,-1},'{'h17f,'h17f,-1,-300},
		'{'h180,'h180,-1,195},'{'h183,'h185,2,-1},'{'h188,'h18c,4,-1},'{'h192,'h192,-1,-1},
		'{'h195,'h195,-1,97},'{'h199,'h199,-1,-1},'{'h19a,'h19a,-1,163},'{'h19e,'h19e,-1,130},
		'{'h1a1,'h1a5,2,-1},'{'h1a8,'h1ad,5,-1},'{'h1b0,'h1b4,4,-1},'{'h1b6,'h1b9,3,-1},
		'{'h1bd,'h1bd,-1,-1},'{'h1bf,'h1bf,-1,56},'{'h1c5,'h1c5,-1,-1},'{'h1c6,'h1c6,-1,-2},
		'{'h1c8,'h1c8,-1,-1},'{'h1c9,'h1c9,-1,-2},'{'h1cb,'h1cb,-1,-1},'{'h1cc,'h1cc,-1,-2},
		'{'h1ce,'h1dc,2,-1},'{'h1dd,'h1dd,-1,-79},'{'h1df,'h1ef,2,-1},'{'h1f2,'h1f2,-1,-1},
		'{'h1f3,'h1f3,-1,-2},'{'h1f5,'h1f9,4,-1},'{'h1fb,'h21f,2,-1},'{'h223,'h233,2,-1},
		'{'h23c,'h23c,-1,-1},'{'h23f,'h240,1,10815},'{'h242,'h247,5,-1},'{'h249,'h24f,2,-1},
		'{'h250,'h250,-1,10783},'{'h251,'h251,-1,10780},'{'h252,'h252,-1,10782},
		'{'h253,'h253,-1,-210},
		'{'h254,'h254,-1,-206},'{'h256,'h257,1,-205},'{'h259,'h259,-1,-202},'{'h25b,'h25b,-1,-203},
		'{'h25c,'h25c,-1,42319},'{'h260,'h260,-1,-205},'{'h261,'h261,-1,42315},
		'{'h263,'h263,-1,-207},
		'{'h265,'h265,-1,42280},'{'h266,'h266,-1,42308},'{'h268,'h268,-1,-209},
		'{'h269,'h269,-1,-211},
		'{'h26a,'h26a,-1,42308},'{'h26b,'h26b,-1,10743},'{'h26c,'h26c,-1,42305},
		'{'h26f,'h26f,-1,-211},
		'{'h271,'h271,-1,10749},'{'h272,'h272,-1,-213},'{'h275,'h275,-1,-214},
		'{'h27d,'h27d,-1,10727},
		'{'h280,'h280,-1,-218},'{'h282,'h282,-1,42307},'{'h283,'h283,-1,-218},
		'{'h287,'h287,-1,42282},
		'{'h288,'h288,-1,-218},'{'h289,'h289,-1,-69},'{'h28a,'h28b,1,-217},'{'h28c,'h28c,-1,-71},
		'{'h292,'h292,-1,-219},'{'h29d,'h29d,-1,42261},'{'h29e,'h29e,-1,42258},
		'{'h345,'h345,-1,84},
		'{'h371,'h373,2,-1},'{'h377,'h377,-1,-1},'{'h37b,'h37d,1,130},'{'h3ac,'h3ac,-1,-38},
		'{'h3ad,'h3af,1,-37},'{'h3b1,'h3c1,1,-32},'{'h3c2,'h3c2,-1,-31},'{'h3c3,'h3cb,1,-32},
		'{'h3cc,'h3cc,-1,-64},'{'h3cd,'h3ce,1,-63},'{'h3d0,'h3d0,-1,-62},'{'h3d1,'h3d1,-1,-57},
		'{'h3d5,'h3d5,-1,-47},'{'h3d6,'h3d6,-1,-54},'{'h3d7,'h3d7,-1,-8},'{'h3d9,'h3ef,2,-1},
		'{'h3f0,'h3f0,-1,-86},'{'h3f1,'h3f1,-1,-80},'{'h3f2,'h3f2,-1,7},'{'h3f3,'h3f3,-1,-116},
		'{'h3f5,'h3f5,-1,-96},'{'h3f8,'h3fb,3,-1},'{'h430,'h44f,1,-32},'{'h450,'h45f,1,-80},
		'{'h461,'h481,2,-1},'{'h48b,'h4bf,2,-1},'{'h4c2,'h4ce,2,-1},'{'h4cf,'h4cf,-1,-15},
		'{'h4d1,'h52f,2,-1},'{'h561,'h586,1,-48},'{'h10d0,'h10fa,1,3008},'{'h10fd,'h10ff,1,3008},
		'{'h13f8,'h13fd,1,-8},'{'h1c80,'h1c80,-1,-6254},'{'h1c81,'h1c81,-1,-6253},
		'{'h1c82,'h1c82,-1,-6244},
		'{'h1c83,'h1c84,1,-6242},'{'h1c85,'h1c85,-1,-6243},'{'h1c86,'h1c86,-1,-6236},
		'{'h1c87,'h1c87,-1,-6181},
		'{'h1c88,'h1c88,-1,35266},'{'h1d79,'h1d79,-1,35332},'{'h1d7d,'h1d7d,-1,3814},
		'{'h1d8e,'h1d8e,-1,35384},
		'{'h1e01,'h1e95,2,-1},'{'h1e9b,'h1e9b,-1,-59},'{'h1ea1,'h1eff,2,-1},'{'h1f00,'h1f07,1,8},
		'{'h1f10,'h1f15,1,8},'{'h1f20,'h1f27,1,8},'{'h1f30,'h1f37,1,8},'{'h1f40,'h1f45,1,8},
		'{'h1f51,'h1f57,2,8},'{'h1f60,'h1f67,1,8},'{'h1f70,'h1f71,1,74},'{'h1f72,'h1f75,1,86},
		'{'h1f76,'h1f77,1,100},'{'h1f78,'h1f79,1,128},'{'h1f7a,'h1f7b,1,112},
		'{'h1f7c,'h1f7d,1,126},
		'{'h1f80,'h1f87,1,8},'{'h1f90,'h1f97,1,8},'{'h1fa0,'h1fa7,1,8},'{'h1fb0,'h1fb1,1,8},
		'{'h1fb3,'h1fb3,-1,9},'{'h1fbe,'h1fbe,-1,-7205},'{'h1fc3,'h1fc3,-1,9},'{'h1fd0,'h1fd1,1,8},
		'{'h1fe0,'h1fe1,1,8},'{'h1fe5,'h1fe5,-1,7},'{'h1ff3,'h1ff3,-1,9},'{'h214e,'h214e,-1,-28},
		'{'h2170,'h217f,1,-16},'{'h2184,'h2184,-1,-1},'{'h24d0,'h24e9,1,-26},
		'{'h2c30,'h2c5e,1,-48},
		'{'h2c61,'h2c61,-1,-1},'{'h2c65,'h2c65,-1,-10795},'{'h2c66,'h2c66,-1,-10792},
		'{'h2c68,'h2c6c,2,-1},
		'{'h2c73,'h2c76,3,-1},'{'h2c81,'h2ce3,2,-1},'{'h2cec,'h2cee,2,-1},'{'h2cf3,'h2cf3,-1,-1},
		'{'h2d00,'h2d25,1,-7264},'{'h2d27,'h2d2d,6,-7264},'{'ha641,'ha66d,2,-1},
		'{'ha681,'ha69b,2,-1},
		'{'ha723,'ha72f,2,-1},'{'ha733,'ha76f,2,-1},'{'ha77a,'ha77c,2,-1},'{'ha77f,'ha787,2,-1},
		'{'ha78c,'ha791,5,-1},'{'ha793,'ha793,-1,-1},'{'ha794,'ha794,-1,48},'{'ha797,'ha7a9,2,-1},
		'{'ha7b5,'ha7bf,2,-1},'{'ha7c3,'ha7c8,5,-1},'{'ha7ca,'ha7f6,44,-1},
		'{'hab53,'hab53,-1,-928},
		'{'hab70,'habbf,1,-38864},'{'hff41,'hff5a,1,-32},'{'h10428,'h1044f,1,-40},
		'{'h104d8,'h104fb,1,-40},
		'{'h10cc0,'h10cf2,1,-64},'{'h118c0,'h118df,1,-32},'{'h16e60,'h16e7f,1,-32},
		'{'h1e922,'h1e943,1,-34}
	};

	// offset from range start lands on the entry's step
	// entries with an odd step other than one span exactly one step,
	// so an in-range offset hits only at the two ends
	function automatic logic stride_hit(diff_t diff, logic signed [15:0] stride);
		logic hit;
		case (stride)
			16'sd1:     hit = 1'b1;
			16'sd2:     hit = ~diff[0];
			16'sd3:     hit = (diff == 16'd0) || (diff == 16'd3);
			16'sd4:     hit = diff[1:0] == 2'd0;
			16'sd5:     hit = (diff == 16'd0) || (diff == 16'd5);
			16'sd6:     hit = (diff == 16'd0) || (diff == 16'd6);
			16'sd44:    hit = (diff == 16'd0) || (diff == 16'd44);
			16'sd31054: hit = (diff == 16'd0) || (diff == 16'd31054) || (diff == 16'd62108);
			default:    hit = diff == 16'd0;
		endcase
		return hit;
	endfunction

endpackage

>>> sv/unicode_case_mapper_top.sv
// unicode_case_mapper_top: pipelined simple case mapping of one code point
// binary search over two range roms unrolled into one stage per search bit
// depends on ucm_pkg
`timescale 1ns / 1ps

// channel   | handshake     | ports
// ----------+---------------+--------------------------------------------------
// input     | start / busy  | code_point
// result    | done strobe   | lower_equiv, upper_equiv, is_lower, is_upper
//
// one word enters per cycle; busy is always low
// the pipe is the input register, one stage per search bit
// of the range roms (9), entry read, then mapping into the output register
// results show for one cycle with done; the receiver cannot stall, so the
// pipe never stalls either
// reset clears only the valid bits; words in flight are dropped
module unicode_case_mapper_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [ucm_pkg::CODE_BITS-1:0] code_point,
	output logic                   done,
	output logic [ucm_pkg::CODE_BITS-1:0] lower_equiv,
	output logic [ucm_pkg::CODE_BITS-1:0] upper_equiv,
	output logic                   is_lower,
	output logic                   is_upper
);
	import ucm_pkg::*;

	// search pipe: stage 0 is the input register, stage k has k bits decided
	logic  vld_s  [SEARCH_STEPS+1];
	code_t cp_s   [SEARCH_STEPS+1];
	pos_t  lpos_s [SEARCH_STEPS+1];
	pos_t  upos_s [SEARCH_STEPS+1];

	// no back pressure anywhere in the pipe
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		cp_s[0]   <= code_point;
		lpos_s[0] <= '0;
		upos_s[0] <= '0;
	end

	// each stage tries to step the lower bound by one power of two
	for (genvar k = 0; k < SEARCH_STEPS; k++) begin : g_search
		localparam int B = SEARCH_STEPS - 1 - k;
		logic [POS_W:0]   lcand, ucand;
		logic [IDX_W-1:0] lidx, uidx;
		logic             lgo, ugo;

		always_comb begin
			lcand = {1'b0, lpos_s[k]} + (POS_W+1)'(1 << B);
			ucand = {1'b0, upos_s[k]} + (POS_W+1)'(1 << B);
			lidx  = IDX_W'(lcand - (POS_W+1)'(1));
			uidx  = IDX_W'(ucand - (POS_W+1)'(1));
			// step only past entries whose range ends below the code point
			lgo = (lcand <= (POS_W+1)'(LOWER_N)) && (LOWER_ROM[lidx].hi < cp_s[k]);
			ugo = (ucand <= (POS_W+1)'(UPPER_N)) && (UPPER_ROM[uidx].hi < cp_s[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			cp_s[k+1]   <= cp_s[k];
			lpos_s[k+1] <= lgo ? POS_W'(lcand) : lpos_s[k];
			upos_s[k+1] <= ugo ? POS_W'(ucand) : upos_s[k];
		end
	end

	// entry read stage: fetch the found entries, test the range bounds
	localparam int L = SEARCH_STEPS;

	span_t lent, uent;
	logic  lfound, ufound;

	always_comb begin
		lfound = lpos_s[L] < POS_W'(LOWER_N);
		ufound = upos_s[L] < POS_W'(UPPER_N);
		lent   = lfound ? LOWER_ROM[lpos_s[L][IDX_W-1:0]] : '0;
		uent   = ufound ? UPPER_ROM[upos_s[L][IDX_W-1:0]] : '0;
	end

	logic               vld_se1;
	code_t              cp_se1;
	logic               lin_se1, uin_se1;
	diff_t              ldiff_se1, udiff_se1;
	logic signed [15:0] lstride_se1, ustride_se1;
	logic signed [17:0] ldelta_se1, udelta_se1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_se1 <= 1'b0;
		end else begin
			vld_se1 <= vld_s[L];
		end
	end

	always_ff @(posedge clk) begin
		cp_se1      <= cp_s[L];
		lin_se1     <= lfound && (lent.lo <= cp_s[L]) && (cp_s[L] <= lent.hi);
		uin_se1     <= ufound && (uent.lo <= cp_s[L]) && (cp_s[L] <= uent.hi);
		ldiff_se1   <= 16'(cp_s[L] - lent.lo);
		udiff_se1   <= 16'(cp_s[L] - uent.lo);
		lstride_se1 <= lent.stride;
		ustride_se1 <= uent.stride;
		ldelta_se1  <= lent.delta;
		udelta_se1  <= uent.delta;
	end

	// mapping stage: step test, offset add, ascii path and flags
	code_t lmap, umap;
	logic  is_ascii;

	always_comb begin
		is_ascii = cp_se1 < CODE_BITS'(ASCII_LIMIT);
		if (is_ascii) begin
			lmap = ((cp_se1 >= CODE_BITS'('h41)) && (cp_se1 <= CODE_BITS'('h5a))) ?
				cp_se1 + CODE_BITS'(ASCII_CASE) : cp_se1;
			umap = ((cp_se1 >= CODE_BITS'('h61)) && (cp_se1 <= CODE_BITS'('h7a))) ?
				cp_se1 - CODE_BITS'(ASCII_CASE) : cp_se1;
		end else begin
			lmap = (lin_se1 && stride_hit(ldiff_se1, lstride_se1)) ?
				cp_se1 + CODE_BITS'(ldelta_se1) : cp_se1;
			umap = (uin_se1 && stride_hit(udiff_se1, ustride_se1)) ?
				cp_se1 + CODE_BITS'(udelta_se1) : cp_se1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_se1;
		end
	end

	always_ff @(posedge clk) begin
		lower_equiv <= lmap;
		upper_equiv <= umap;
		// sharp s counts as lower case though it has no simple upper mapping
		is_lower    <= (umap != cp_se1) || (cp_se1 == CODE_BITS'(SHARP_S));
		is_upper    <= lmap != cp_se1;
	end

endmodule

>>> sv/ucm_checker.sv
// ucm_checker: port-level checks of the case mapper pipeline
// bound to unicode_case_mapper_top; depends on ucm_pkg
`timescale 1ns / 1ps

module ucm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [ucm_pkg::CODE_BITS-1:0] code_point,
	input logic                          done,
	input logic [ucm_pkg::CODE_BITS-1:0] lower_equiv,
	input logic [ucm_pkg::CODE_BITS-1:0] upper_equiv,
	input logic                          is_lower,
	input logic                          is_upper
);
	import ucm_pkg::*;

	// every accepted word comes out after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("accepted word lost in pipe");

	// no result without a word accepted the latency before
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result without accepted word");

	// upper flag matches the lower mapping of the word that went in
	a_upper_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_upper == (lower_equiv != $past(code_point, PIPE_LATENCY))))
		else $error("is_upper inconsistent with lower_equiv");

	// lower flag matches the upper mapping, with the sharp s exception
	a_lower_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_lower == ((upper_equiv != $past(code_point, PIPE_LATENCY)) ||
			($past(code_point, PIPE_LATENCY) == CODE_BITS'(SHARP_S)))))
		else $error("is_lower inconsistent with upper_equiv");

endmodule

bind unicode_case_mapper_top ucm_checker u_ucm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.code_point  (code_point),
	.done        (done),
	.lower_equiv (lower_equiv),
	.upper_equiv (upper_equiv),
	.is_lower    (is_lower),
	.is_upper    (is_upper)
);
